// ===== hdl/smte_pkg.sv =====
// smte_pkg: shared types and constants for the spi master transaction engine
// item layouts, phase codes and configuration register indexes
// no dependencies
package smte_pkg;

    localparam int IN_BITS     = 19;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int OUT_BITS    = 39;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // first field in the highest bits
    typedef struct packed {
        logic        miso_level;
        logic [15:0] write_word;
        logic        write_valid;
        logic        start_req;
    } in_item_t;

    typedef struct packed {
        logic        done_res;
        logic        busy_res;
        logic [15:0] read_index;
        logic [15:0] read_word;
        logic        read_valid;
        logic        write_request;
        logic        cs_level;
        logic        mosi_level;
        logic        sclk_level;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_head_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_SHIFT,
        PH_FINISH
    } phase_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WORD_SIXTEEN,
        CFG_CLOCK_IDLE_HIGH,
        CFG_SAMPLE_ON_RISING,
        CFG_CLOCK_DIV_CODE,
        CFG_CS_ACTIVE_HIGH,
        CFG_WRITE_COUNT,
        CFG_READ_COUNT,
        CFG_READ_OFFSET
    } cfg_idx_t;

endpackage

// ===== hdl/smte_front.sv =====
// smte_front: input side, unpacks tick transactions into a short queue
// depends on smte_pkg
module smte_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  smte_pkg::in_item_t                   in_item,
    output smte_pkg::queue_head_t                head,
    input  logic                                 pop
);
    import smte_pkg::*;

    in_item_t               mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   push;
    logic                   pop_ok;

    assign s_tready   = (count_reg != QCNT_BITS'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign pop_ok     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/smte_engine.sv =====
// smte_engine: serial clock divider, shifter and word sequencer, one tick per step
// holds the configuration registers and the result register; depends on smte_pkg
module smte_engine #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [smte_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [smte_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  smte_pkg::queue_head_t                  head,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output smte_pkg::out_item_t                    out_item,
    output logic                                   out_last
);
    import smte_pkg::*;

    localparam int CW = COUNT_BITS;

    logic                word_sixteen_reg;
    logic                clock_idle_high_reg;
    logic                sample_on_rising_reg;
    logic [2:0]          clock_div_code_reg;
    logic                cs_active_high_reg;
    logic [CW-1:0]       write_count_reg;
    logic [CW-1:0]       read_count_reg;
    logic [CW-1:0]       read_offset_reg;

    phase_t              phase_reg, phase_next;
    logic [15:0]         tx_shift_reg, tx_shift_next;
    logic [15:0]         rx_shift_reg, rx_shift_next;
    logic [15:0]         hold_word_reg, hold_word_next;
    logic                hold_full_reg, hold_full_next;
    logic [4:0]          bit_counter_reg, bit_counter_next;
    logic [7:0]          div_counter_reg, div_counter_next;
    logic                clock_state_reg, clock_state_next;
    logic [CW:0]         word_position_reg, word_position_next;
    logic [CW-1:0]       fetched_count_reg, fetched_count_next;

    logic                out_valid_reg;
    out_item_t           out_item_reg, out_item_next;
    logic                out_last_reg, out_last_next;

    logic                step;
    logic                cpha;
    logic                accept;
    logic [CW:0]         total;
    logic [CW:0]         total_raw;
    logic [CW+1:0]       pos_inc;
    logic                last_word;
    logic [3:0]          tx_idx;
    logic [3:0]          tx_bit;
    in_item_t            it;

    assign it        = head.item;
    assign step      = head.valid && (!out_valid_reg || out_ready);
    assign pop       = step;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_last  = out_last_reg;

    assign cpha      = clock_idle_high_reg ^ ~sample_on_rising_reg;
    assign accept    = (phase_reg != PH_IDLE) && !hold_full_reg &&
                       (fetched_count_reg < write_count_reg) && it.write_valid;
    assign total_raw = (read_count_reg != '0)
                       ? ({1'b0, read_count_reg} + {1'b0, read_offset_reg})
                       : {1'b0, write_count_reg};
    assign total     = (total_raw == '0) ? (CW+1)'(1) : total_raw;
    assign pos_inc   = {1'b0, word_position_reg} + (CW+2)'(1);
    assign last_word = pos_inc >= {1'b0, total};

    always_comb
    begin
        phase_next         = phase_reg;
        tx_shift_next      = tx_shift_reg;
        rx_shift_next      = rx_shift_reg;
        hold_word_next     = hold_word_reg;
        hold_full_next     = hold_full_reg;
        bit_counter_next   = bit_counter_reg;
        div_counter_next   = div_counter_reg;
        clock_state_next   = clock_state_reg;
        word_position_next = word_position_reg;
        fetched_count_next = fetched_count_reg;
        out_item_next      = '0;
        out_last_next      = 1'b0;
        tx_idx             = '0;
        tx_bit             = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                clock_state_next = clock_idle_high_reg;
                if (it.start_req)
                begin
                    phase_next         = PH_LOAD;
                    fetched_count_next = '0;
                    word_position_next = '0;
                    hold_full_next     = 1'b0;
                    tx_shift_next      = '0;
                    rx_shift_next      = '0;
                    bit_counter_next   = '0;
                    div_counter_next   = '0;
                end
            end
            PH_LOAD:
            begin
                clock_state_next = clock_idle_high_reg;
                if (hold_full_reg || (fetched_count_reg >= write_count_reg))
                begin
                    if (hold_full_reg)
                    begin
                        tx_shift_next  = hold_word_reg;
                        hold_full_next = 1'b0;
                    end
                    bit_counter_next = '0;
                    div_counter_next = '0;
                    phase_next       = PH_SHIFT;
                end
            end
            PH_SHIFT:
            begin
                if (({1'b0, div_counter_reg} + 9'd1) >= (9'd1 << clock_div_code_reg))
                begin
                    div_counter_next = '0;
                    clock_state_next = ~clock_state_reg;
                    if (bit_counter_reg[0] == cpha)
                    begin
                        rx_shift_next = {rx_shift_reg[14:0], it.miso_level};
                    end
                    if (({1'b0, bit_counter_reg} + 6'd1) >=
                        (word_sixteen_reg ? 6'd32 : 6'd16))
                    begin
                        if ((read_count_reg != '0) &&
                            (word_position_reg >= {1'b0, read_offset_reg}))
                        begin
                            out_item_next.read_valid = 1'b1;
                            out_item_next.read_word  = word_sixteen_reg ? rx_shift_next
                                                       : {8'h00, rx_shift_next[7:0]};
                            out_item_next.read_index =
                                16'(word_position_reg - {1'b0, read_offset_reg});
                            out_last_next = last_word;
                        end
                        word_position_next = pos_inc[CW:0];
                        bit_counter_next   = '0;
                        phase_next         = last_word ? PH_FINISH : PH_LOAD;
                    end
                    else
                    begin
                        bit_counter_next = bit_counter_reg + 5'd1;
                    end
                end
                else
                begin
                    div_counter_next = div_counter_reg + 8'd1;
                end
            end
            PH_FINISH:
            begin
                phase_next             = PH_IDLE;
                hold_full_next         = 1'b0;
                clock_state_next       = clock_idle_high_reg;
                out_item_next.done_res = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (accept && (phase_next != PH_IDLE))
        begin
            hold_word_next     = it.write_word;
            hold_full_next     = 1'b1;
            fetched_count_next = fetched_count_reg + 1'b1;
        end

        if (phase_next == PH_SHIFT)
        begin
            if (cpha)
            begin
                tx_idx = (bit_counter_next == '0) ? 4'd0 : 4'((bit_counter_next - 5'd1) >> 1);
            end
            else
            begin
                tx_idx = bit_counter_next[4:1];
            end
            tx_bit = (word_sixteen_reg ? 4'd15 : 4'd7) - tx_idx;
            if (word_sixteen_reg || !tx_idx[3])
            begin
                out_item_next.mosi_level = tx_shift_next[tx_bit];
            end
        end

        out_item_next.sclk_level    = clock_state_next;
        out_item_next.cs_level      = (phase_next != PH_IDLE) ? cs_active_high_reg
                                                               : ~cs_active_high_reg;
        out_item_next.write_request = (phase_next != PH_IDLE) && !hold_full_next &&
                                      (fetched_count_next < write_count_reg);
        out_item_next.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_sixteen_reg     <= 1'b0;
            clock_idle_high_reg  <= 1'b0;
            sample_on_rising_reg <= 1'b1;
            clock_div_code_reg   <= '0;
            cs_active_high_reg   <= 1'b0;
            write_count_reg      <= '0;
            read_count_reg       <= '0;
            read_offset_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WORD_SIXTEEN:     word_sixteen_reg     <= cfg_data[0];
                CFG_CLOCK_IDLE_HIGH:  clock_idle_high_reg  <= cfg_data[0];
                CFG_SAMPLE_ON_RISING: sample_on_rising_reg <= cfg_data[0];
                CFG_CLOCK_DIV_CODE:   clock_div_code_reg   <= cfg_data[2:0];
                CFG_CS_ACTIVE_HIGH:   cs_active_high_reg   <= cfg_data[0];
                CFG_WRITE_COUNT:      write_count_reg      <= CW'(cfg_data);
                CFG_READ_COUNT:       read_count_reg       <= CW'(cfg_data);
                CFG_READ_OFFSET:      read_offset_reg      <= CW'(cfg_data);
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tx_shift_reg      <= '0;
            rx_shift_reg      <= '0;
            hold_word_reg     <= '0;
            hold_full_reg     <= 1'b0;
            bit_counter_reg   <= '0;
            div_counter_reg   <= '0;
            clock_state_reg   <= 1'b0;
            word_position_reg <= '0;
            fetched_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg         <= phase_next;
                tx_shift_reg      <= tx_shift_next;
                rx_shift_reg      <= rx_shift_next;
                hold_word_reg     <= hold_word_next;
                hold_full_reg     <= hold_full_next;
                bit_counter_reg   <= bit_counter_next;
                div_counter_reg   <= div_counter_next;
                clock_state_reg   <= clock_state_next;
                word_position_reg <= word_position_next;
                fetched_count_reg <= fetched_count_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= out_item_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

// ===== hdl/spi_master_transaction_engine.sv =====
// spi_master_transaction_engine: top level, tick queue in front of the spi engine
// depends on smte_pkg, smte_front, smte_engine
//
//  channel   group                   carries
//  input     s_tvalid/s_tready       one system tick: start, write word, miso sample
//  output    m_tvalid/m_tready       line levels and read word after that tick
//  config    cfg_we/cfg_index        register write, no handshake
//
// one transaction in and one out per cycle, sustained while m_tready stays high
// path: queue register, then the engine step into the result register
// the engine steps only when the result register is empty or being taken
// a two-entry queue absorbs a tick while the output stalls, before s_tready drops
// reset clears the engine state and output valid, not the result data; no clearing pass
module spi_master_transaction_engine #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // start_req, write_valid, write_word[15:0], miso_level, zero pad
    input  logic [smte_pkg::IN_BYTES*8-1:0]           s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // sclk_level, mosi_level, cs_level, write_request, read_valid,
    // read_word[15:0], read_index[15:0], busy_res, done_res, zero pad
    output logic [smte_pkg::OUT_BYTES*8-1:0]          m_tdata,
    output logic                                      m_tlast,
    input  logic                                      cfg_we,
    input  logic [smte_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [smte_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
    import smte_pkg::*;

    queue_head_t head;
    logic        pop;
    out_item_t   out_item;

    smte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_item  (in_item_t'(s_tdata[IN_BITS-1:0])),
        .head     (head),
        .pop      (pop)
    );

    smte_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_item};

endmodule

// ===== hdl/smte_checker.sv =====
// smte_checker: port-level checks on the spi master transaction engine
// depends on smte_pkg; bound to the top level below
module smte_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [smte_pkg::OUT_BYTES*8-1:0]     m_tdata,
    input  logic                                 m_tlast
);
    import smte_pkg::*;

    out_item_t o;
    assign o = out_item_t'(m_tdata[OUT_BITS-1:0]);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o.done_res |-> !o.busy_res)
        else $error("done with busy still set");

    a_last_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> o.read_valid)
        else $error("last marker without read word");

    a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !o.read_valid |-> (o.read_word == '0) && (o.read_index == '0) && !m_tlast)
        else $error("read fields set without read word");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o.write_request |-> o.busy_res && !o.done_res)
        else $error("write request outside transaction");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind spi_master_transaction_engine smte_checker u_smte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
